[rtl/dle_frame_unstuffer_assert.svh]
// ----------------------------------------------------------------------------
// dle_frame_unstuffer_assert.svh
// Assertion macros used by the DLE frame unstuffer parser.
// ----------------------------------------------------------------------------
`ifndef DLE_FRAME_UNSTUFFER_ASSERT_SVH
`define DLE_FRAME_UNSTUFFER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DFU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define DFU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/dfu_pkg.sv]
// ----------------------------------------------------------------------------
// dfu_pkg
// Types and constants of the DLE frame unstuffer.
// ----------------------------------------------------------------------------
package dfu_pkg;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 9;
    localparam int KIND_W  = 2;
    localparam int MODE_W  = 2;

    localparam logic [BYTE_W-1:0] BYTE_DLE = 8'h10;
    localparam logic [BYTE_W-1:0] BYTE_STX = 8'h02;
    localparam logic [BYTE_W-1:0] BYTE_ETX = 8'h03;

    localparam logic [MODE_W-1:0] MODE_HUNT      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HUNT_DLE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FRAME     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_FRAME_DLE = 2'd3;

    localparam logic [KIND_W-1:0] EV_DATA  = 2'd0;
    localparam logic [KIND_W-1:0] EV_END   = 2'd1;
    localparam logic [KIND_W-1:0] EV_EMPTY = 2'd2;
    localparam logic [KIND_W-1:0] EV_OVER  = 2'd3;

    localparam logic [COUNT_W-1:0] MAX_LEN_RESET = 9'd256;

    // Held byte in the input stage.
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] rx_byte;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [KIND_W-1:0]  event_kind;
        logic [BYTE_W-1:0]  data_byte;
        logic [COUNT_W-1:0] byte_index;
    } t_event;

endpackage

[rtl/dfu_in_stage.sv]
// ----------------------------------------------------------------------------
// dfu_in_stage
// Input register: holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module dfu_in_stage (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [dfu_pkg::BYTE_W-1:0]  i_rx_byte,
    input  logic                        i_take,
    output dfu_pkg::t_in_item           o_item
);

    logic                       r_valid;
    logic [dfu_pkg::BYTE_W-1:0] r_byte;
    logic                       n_valid;

    assign o_in_ready = !r_valid || i_take;

    always_comb begin
        n_valid = r_valid;
        if (o_in_ready) begin
            n_valid = i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Load payload on every accepted transaction.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_byte <= i_rx_byte;
        end
    end

    assign o_item.valid   = r_valid;
    assign o_item.rx_byte = r_byte;

endmodule

[rtl/dfu_parser.sv]
// ----------------------------------------------------------------------------
// dfu_parser
// Framing state machine, frame counter and length limit register.
// ----------------------------------------------------------------------------
`include "dle_frame_unstuffer_assert.svh"

module dfu_parser #(
    parameter int unsigned MAX_FRAME = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  logic [dfu_pkg::COUNT_W-1:0]  i_cfg_max_frame_len,
    input  dfu_pkg::t_in_item            i_item,
    input  logic                         i_out_free,
    output logic                         o_take,
    output logic                         o_evt_valid,
    output dfu_pkg::t_event              o_evt
);

    // Largest limit the counter width can express.
    localparam int unsigned CountMax = (1 << dfu_pkg::COUNT_W) - 1;
    localparam int unsigned LimitCapInt = (MAX_FRAME > CountMax) ? CountMax : MAX_FRAME;
    localparam logic [dfu_pkg::COUNT_W-1:0] LIMIT_CAP = dfu_pkg::COUNT_W'(LimitCapInt);

    logic [dfu_pkg::MODE_W-1:0]  r_mode;
    logic [dfu_pkg::MODE_W-1:0]  n_mode;
    logic [dfu_pkg::COUNT_W-1:0] r_count;
    logic [dfu_pkg::COUNT_W-1:0] n_count;
    logic [dfu_pkg::COUNT_W-1:0] r_max_len;
    logic [dfu_pkg::COUNT_W-1:0] w_limit;
    logic                        w_has_evt;
    logic                        w_is_data;
    logic [dfu_pkg::BYTE_W-1:0]  w_data;
    dfu_pkg::t_event             w_evt;

    assign o_take  = i_item.valid && i_out_free;
    assign w_limit = (r_max_len > LIMIT_CAP) ? LIMIT_CAP : r_max_len;

    always_comb begin
        n_mode    = r_mode;
        n_count   = r_count;
        w_has_evt = 1'b0;
        w_is_data = 1'b0;
        w_data    = i_item.rx_byte;
        w_evt     = '0;
        unique case (r_mode)
            dfu_pkg::MODE_HUNT: begin
                if (i_item.rx_byte == dfu_pkg::BYTE_DLE) begin
                    n_mode = dfu_pkg::MODE_HUNT_DLE;
                end
            end
            dfu_pkg::MODE_HUNT_DLE: begin
                if (i_item.rx_byte == dfu_pkg::BYTE_STX) begin
                    n_mode  = dfu_pkg::MODE_FRAME;
                    n_count = '0;
                end else begin
                    n_mode = dfu_pkg::MODE_HUNT;
                end
            end
            dfu_pkg::MODE_FRAME: begin
                if (i_item.rx_byte == dfu_pkg::BYTE_DLE) begin
                    n_mode = dfu_pkg::MODE_FRAME_DLE;
                end else begin
                    w_is_data = 1'b1;
                end
            end
            dfu_pkg::MODE_FRAME_DLE: begin
                if (i_item.rx_byte == dfu_pkg::BYTE_ETX) begin
                    w_has_evt = 1'b1;
                    n_mode    = dfu_pkg::MODE_HUNT;
                    n_count   = '0;
                    if (r_count == '0) begin
                        w_evt.event_kind = dfu_pkg::EV_EMPTY;
                    end else begin
                        w_evt.event_kind = dfu_pkg::EV_END;
                        w_evt.byte_index = r_count;
                    end
                end else if (i_item.rx_byte == dfu_pkg::BYTE_DLE) begin
                    w_is_data = 1'b1;
                    w_data    = dfu_pkg::BYTE_DLE;
                end else begin
                    n_mode = dfu_pkg::MODE_FRAME;
                end
            end
            default: begin
                n_mode = dfu_pkg::MODE_HUNT;
            end
        endcase

        // Emit a data byte, or drop the frame once it reaches the limit.
        if (w_is_data) begin
            w_has_evt        = 1'b1;
            w_evt.byte_index = r_count;
            if (r_count >= w_limit) begin
                w_evt.event_kind = dfu_pkg::EV_OVER;
                n_mode           = dfu_pkg::MODE_HUNT;
                n_count          = '0;
            end else begin
                w_evt.event_kind = dfu_pkg::EV_DATA;
                w_evt.data_byte  = w_data;
                n_mode           = dfu_pkg::MODE_FRAME;
                n_count          = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= dfu_pkg::MODE_HUNT;
            r_count   <= '0;
            r_max_len <= dfu_pkg::MAX_LEN_RESET;
        end else begin
            if (o_take) begin
                r_mode  <= n_mode;
                r_count <= n_count;
            end
            if (i_cfg_valid) begin
                r_max_len <= i_cfg_max_frame_len;
            end
        end
    end

    assign o_evt_valid = o_take && w_has_evt;
    assign o_evt       = w_evt;

    `DFU_ASSERT_NOW(a_hunt_count_zero, i_clk, i_rst_n,
        (r_mode == dfu_pkg::MODE_HUNT) || (r_mode == dfu_pkg::MODE_HUNT_DLE),
        r_count == '0, "frame counter nonzero while hunting")
    `DFU_ASSERT_NOW(a_data_below_limit, i_clk, i_rst_n,
        o_evt_valid && (o_evt.event_kind == dfu_pkg::EV_DATA),
        o_evt.byte_index < w_limit, "data byte index at or above limit")
    `DFU_ASSERT_NOW(a_ctrl_data_zero, i_clk, i_rst_n,
        o_evt_valid && (o_evt.event_kind != dfu_pkg::EV_DATA),
        o_evt.data_byte == '0, "frame event carries a data byte")
    `DFU_ASSERT_NEXT(a_over_hunts, i_clk, i_rst_n,
        o_evt_valid && (o_evt.event_kind == dfu_pkg::EV_OVER),
        r_mode == dfu_pkg::MODE_HUNT, "overflow did not return to hunting")

endmodule

[rtl/dfu_out_stage.sv]
// ----------------------------------------------------------------------------
// dfu_out_stage
// Result register: holds one event until the consumer takes it.
// ----------------------------------------------------------------------------
module dfu_out_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_evt_valid,
    input  dfu_pkg::t_event i_evt,
    output logic            o_free,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output dfu_pkg::t_event o_evt
);

    logic            r_valid;
    logic            n_valid;
    dfu_pkg::t_event r_evt;

    // Slot can take a new event when empty or draining this cycle.
    assign o_free = !r_valid || i_out_ready;

    always_comb begin
        n_valid = r_valid;
        if (o_free) begin
            n_valid = i_evt_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_evt_valid) begin
            r_evt <= i_evt;
        end
    end

    assign o_out_valid = r_valid;
    assign o_evt       = r_evt;

endmodule

[rtl/dle_frame_unstuffer.sv]
// ----------------------------------------------------------------------------
// dle_frame_unstuffer
// Removes DLE/STX/ETX framing from a received byte stream and reports data
// bytes with their index, frame ends with their length, and frame errors.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake               Payload
//  cfg      in         i_cfg_valid/o_cfg_ready i_cfg_max_frame_len[8:0]
//  in       in         i_in_valid/o_in_ready   i_rx_byte[7:0]
//  out      out        o_out_valid/i_out_ready o_event_kind/o_data_byte/o_byte_index
//
//  One byte per cycle sustained while the output is not stalled. An accepted
//  byte sits in the input register while the state machine decodes it; its
//  event, if any, loads into the result register when the parser takes the
//  byte, and the consumer takes it from there.
//  Reset (synchronous, active low) returns to hunting, clears the frame
//  counter and sets the length limit to 256. A stalled output holds both
//  registers; input resumes in the same cycle the consumer takes the result.
//
module dle_frame_unstuffer #(
    parameter int unsigned MAX_FRAME = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration transaction
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [dfu_pkg::COUNT_W-1:0]  i_cfg_max_frame_len,
    // received byte transaction
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [dfu_pkg::BYTE_W-1:0]   i_rx_byte,
    // event transaction
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [dfu_pkg::KIND_W-1:0]   o_event_kind,
    output logic [dfu_pkg::BYTE_W-1:0]   o_data_byte,
    output logic [dfu_pkg::COUNT_W-1:0]  o_byte_index
);

    dfu_pkg::t_in_item w_item;
    dfu_pkg::t_event   w_evt;
    dfu_pkg::t_event   w_out_evt;
    logic              w_take;
    logic              w_out_free;
    logic              w_evt_valid;

    // Limit register always accepts; user must write only while idle (unchecked).
    assign o_cfg_ready = 1'b1;

    // Hold the incoming byte until the parser takes it.
    dfu_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_rx_byte  (i_rx_byte),
        .i_take     (w_take),
        .o_item     (w_item)
    );

    // Decode framing; advance only when the result slot can take an event.
    dfu_parser #(
        .MAX_FRAME (MAX_FRAME)
    ) u_parser (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_max_frame_len (i_cfg_max_frame_len),
        .i_item              (w_item),
        .i_out_free          (w_out_free),
        .o_take              (w_take),
        .o_evt_valid         (w_evt_valid),
        .o_evt               (w_evt)
    );

    // Register the event toward the consumer.
    dfu_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt_valid (w_evt_valid),
        .i_evt       (w_evt),
        .o_free      (w_out_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_evt       (w_out_evt)
    );

    assign o_event_kind = w_out_evt.event_kind;
    assign o_data_byte  = w_out_evt.data_byte;
    assign o_byte_index = w_out_evt.byte_index;

endmodule
